// File: hdl/assert_macros.svh
// Assertion macros shared by the keyboard key queue RTL.
// Included by files that carry concurrent assertions; needs no package.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising clock edge outside reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Next-cycle implication, checked at every rising clock edge outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// File: hdl/kbq_pkg.sv
// Package for the keyboard key queue: types, codes, host key constants,
// the key matrix table and the host key translation. No dependencies.
package kbq_pkg;

   localparam int KBQ_QUEUE_DEPTH = 16;

   localparam int KBQ_ENTRY_W = 11;
   localparam int KBQ_CHAR_W  = 8;

   typedef enum logic [1:0] {
      OP_PUSH  = 2'd0,
      OP_READ  = 2'd1,
      OP_WRITE = 2'd2,
      OP_NONE  = 2'd3
   } kbq_op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_RESP
   } kbq_state_type;

   typedef struct packed {
      logic load;
      logic exec;
   } kbq_cmd_type;

   // Serial bit addresses.
   localparam logic [4:0] ADDR_ROW_FIRST = 5'd3;
   localparam logic [4:0] ADDR_ROW_LAST  = 5'd10;
   localparam logic [4:0] ADDR_LAST_COL  = 5'd5;
   localparam logic [4:0] ADDR_FN        = 5'd7;
   localparam logic [4:0] ADDR_SHIFT     = 5'd8;
   localparam logic [4:0] ADDR_CTRL      = 5'd9;
   localparam logic [4:0] ADDR_COL0      = 5'd18;
   localparam logic [4:0] ADDR_COL1      = 5'd19;
   localparam logic [4:0] ADDR_COL2      = 5'd20;
   localparam logic [4:0] ADDR_CAPS      = 5'd21;

   localparam logic [2:0] COL_FIRST_DEAD = 3'd6;

   // Host key codes.
   localparam logic [23:0] HK_BKSP  = 24'h000008;
   localparam logic [23:0] HK_DEL   = 24'h00007F;
   localparam logic [23:0] HK_ESC   = 24'h00001B;
   localparam logic [23:0] HK_UP    = 24'h415B1B;
   localparam logic [23:0] HK_DOWN  = 24'h425B1B;
   localparam logic [23:0] HK_RIGHT = 24'h435B1B;
   localparam logic [23:0] HK_LEFT  = 24'h445B1B;
   localparam logic [23:0] HK_ESC_MASK = 24'hFF00FF;
   localparam logic [7:0]  BYTE_MASK   = 8'hFF;

   localparam logic [2:0] FLAG_FN    = 3'b001;
   localparam logic [2:0] FLAG_SHIFT = 3'b010;
   localparam logic [2:0] FLAG_CTRL  = 3'b100;
   localparam logic [2:0] FLAG_NONE  = 3'b000;

   // Character at one row and column of the 8x6 key matrix.
   function automatic logic [7:0] matrix_char(input logic [2:0] row, input logic [2:0] col);
      logic [47:0] line;
      logic [7:0]  ch;
      begin
         unique case (row)
            3'd0:    line = {"/", "N", "M", ",", ".", "="};
            3'd1:    line = {";", "H", "J", "K", "L", " "};
            3'd2:    line = {"P", "Y", "U", "I", "O", 8'h0A};
            3'd3:    line = {"0", "6", "7", "8", "9", 8'h00};
            3'd4:    line = {"1", "5", "4", "3", "2", 8'h00};
            3'd5:    line = {"A", "G", "F", "D", "S", 8'h00};
            3'd6:    line = {"Q", "T", "R", "E", "W", 8'h00};
            default: line = {"Z", "B", "V", "C", "X", 8'h00};
         endcase
         unique case (col)
            3'd0:    ch = line[7:0];
            3'd1:    ch = line[15:8];
            3'd2:    ch = line[23:16];
            3'd3:    ch = line[31:24];
            3'd4:    ch = line[39:32];
            3'd5:    ch = line[47:40];
            default: ch = 8'h00;
         endcase
         return ch;
      end
   endfunction

   // Host key to key entry: {ctrl, shift, fn, character}.
   function automatic logic [10:0] translate(input logic [23:0] hk);
      logic [7:0] c;
      logic [10:0] ent;
      begin
         c = hk[7:0] & BYTE_MASK;
         case (hk) inside
            24'h00007E: ent = {FLAG_FN, "W"};
            24'h00005B: ent = {FLAG_FN, "R"};
            24'h00005D: ent = {FLAG_FN, "T"};
            24'h00005F: ent = {FLAG_FN, "U"};
            24'h00003F: ent = {FLAG_FN, "I"};
            24'h000027: ent = {FLAG_FN, "O"};
            24'h000022: ent = {FLAG_FN, "P"};
            24'h00007C: ent = {FLAG_FN, "A"};
            24'h00007B: ent = {FLAG_FN, "F"};
            24'h00007D: ent = {FLAG_FN, "G"};
            24'h00005C: ent = {FLAG_FN, "Z"};
            24'h000060: ent = {FLAG_FN, "C"};
            24'h000021: ent = {FLAG_SHIFT, "1"};
            24'h000040: ent = {FLAG_SHIFT, "2"};
            24'h000023: ent = {FLAG_SHIFT, "3"};
            24'h000024: ent = {FLAG_SHIFT, "4"};
            24'h000025: ent = {FLAG_SHIFT, "5"};
            24'h00005E: ent = {FLAG_SHIFT, "6"};
            24'h000026: ent = {FLAG_SHIFT, "7"};
            24'h00002A: ent = {FLAG_SHIFT, "8"};
            24'h000028: ent = {FLAG_SHIFT, "9"};
            24'h000029: ent = {FLAG_SHIFT, "0"};
            24'h00002B: ent = {FLAG_SHIFT, "="};
            24'h00002D: ent = {FLAG_SHIFT, "/"};
            24'h00003A: ent = {FLAG_SHIFT, ";"};
            24'h00003C: ent = {FLAG_SHIFT, ","};
            24'h00003E: ent = {FLAG_SHIFT, "."};
            24'h00000A,
            24'h00000D: ent = {FLAG_NONE, 8'h0A};
            HK_BKSP,
            HK_DEL,
            HK_LEFT:    ent = {FLAG_FN, "S"};
            HK_RIGHT:   ent = {FLAG_FN, "D"};
            HK_UP:      ent = {FLAG_FN, "E"};
            HK_DOWN:    ent = {FLAG_FN, "X"};
            default: begin
               if (hk < HK_ESC) begin
                  // Control codes map to ctrl plus 'A'+c-1, so code 0 gives '@'.
                  ent = {FLAG_CTRL, 8'(8'h40 + hk[7:0])};
               end else if ((hk & HK_ESC_MASK) == HK_ESC) begin
                  ent = {FLAG_FN, hk[15:8]};
               end else if (c >= "A" && c <= "Z") begin
                  ent = {FLAG_SHIFT, c};
               end else if (c >= "a" && c <= "z") begin
                  ent = {FLAG_NONE, 8'(c - 8'h20)};
               end else begin
                  ent = {FLAG_NONE, c};
               end
            end
         endcase
         return ent;
      end
   endfunction

endpackage

// File: hdl/kbq_ctrl.sv
// Controller for the keyboard key queue: accept, execute, respond sequence.
// Depends on kbq_pkg for the state and command types.
module kbq_ctrl
   import kbq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output kbq_cmd_type cmd
);

   kbq_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            state_in = ST_RESP;
         end
         ST_RESP: begin
            rsp_valid = 1'b1;
            // A new item may enter in the cycle the result leaves.
            req_stall = rsp_stall;
            if (!rsp_stall) begin
               if (req_valid) begin
                  cmd.load = 1'b1;
                  state_in = ST_EXEC;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

// File: hdl/kbq_dp.sv
// Datapath for the keyboard key queue: item registers, key queue memory,
// pointers, column select, caps flag and result registers. Uses kbq_pkg.
module kbq_dp
   import kbq_pkg::*;
#(
   parameter int QUEUE_DEPTH = KBQ_QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  kbq_cmd_type cmd,
   input  logic [1:0]  req_opcode,
   input  logic [4:0]  req_bit_address,
   input  logic        req_write_bit,
   input  logic [23:0] req_host_key,
   output logic        rsp_read_bit,
   output logic        rsp_handled
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

   logic [KBQ_ENTRY_W-1:0] mem [QUEUE_DEPTH];
   logic [KBQ_ENTRY_W-1:0] rd_data_ff;

   kbq_op_type  op_ff;
   logic [4:0]  addr_ff;
   logic        wbit_ff;
   logic [23:0] hk_ff;

   logic [PTR_W-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [2:0]       col_ff, col_in;
   logic             caps_ff, caps_in;
   logic             read_bit_ff, read_bit_in;
   logic             handled_ff, handled_in;

   logic [KBQ_ENTRY_W-1:0] push_entry;
   logic                   push_en;
   logic [2:0]             row;
   logic                   row_match;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff   <= kbq_op_type'(req_opcode);
         addr_ff <= req_bit_address;
         wbit_ff <= req_write_bit;
         hk_ff   <= req_host_key;
      end
   end

   assign push_entry = translate(hk_ff);
   assign push_en    = cmd.exec && (op_ff == OP_PUSH);

   // Key queue storage: write at the head, registered read at the tail.
   always_ff @(posedge clock) begin
      if (push_en) begin
         mem[head_ff] <= push_entry;
      end
      rd_data_ff <= mem[tail_ff];
   end

   assign row       = 3'(addr_ff - ADDR_ROW_FIRST);
   assign row_match = (col_ff < COL_FIRST_DEAD) &&
                      (matrix_char(row, col_ff) == rd_data_ff[KBQ_CHAR_W-1:0]);

   always_comb begin
      head_in     = head_ff;
      tail_in     = tail_ff;
      col_in      = col_ff;
      caps_in     = caps_ff;
      read_bit_in = 1'b1;
      handled_in  = 1'b0;
      case (op_ff)
         OP_PUSH: begin
            head_in = (head_ff == PTR_LAST) ? '0 : head_ff + 1'b1;
         end
         OP_READ: begin
            if (addr_ff >= ADDR_ROW_FIRST && addr_ff <= ADDR_ROW_LAST) begin
               handled_in = 1'b1;
               if (!caps_ff && addr_ff == ADDR_FN) begin
                  read_bit_in = 1'b1;
               end else if (head_ff == tail_ff) begin
                  read_bit_in = 1'b1;
               end else if (col_ff == 3'd0 && addr_ff > ADDR_LAST_COL) begin
                  // Column 0 rows beyond the keys carry the modifier flags.
                  if (addr_ff == ADDR_FN) begin
                     read_bit_in = !rd_data_ff[8];
                  end else if (addr_ff == ADDR_SHIFT) begin
                     read_bit_in = !rd_data_ff[9];
                  end else if (addr_ff == ADDR_CTRL) begin
                     read_bit_in = !rd_data_ff[10];
                  end else begin
                     read_bit_in = 1'b1;
                  end
               end else begin
                  if (col_ff == 3'd0 && addr_ff == ADDR_ROW_FIRST) begin
                     tail_in = (tail_ff == PTR_LAST) ? '0 : tail_ff + 1'b1;
                  end
                  read_bit_in = !row_match;
               end
            end
         end
         OP_WRITE: begin
            unique case (addr_ff)
               ADDR_COL0: begin
                  col_in[0]  = wbit_ff;
                  handled_in = 1'b1;
               end
               ADDR_COL1: begin
                  col_in[1]  = wbit_ff;
                  handled_in = 1'b1;
               end
               ADDR_COL2: begin
                  col_in[2]  = wbit_ff;
                  handled_in = 1'b1;
               end
               ADDR_CAPS: begin
                  caps_in    = wbit_ff;
                  handled_in = 1'b1;
               end
               default: handled_in = 1'b0;
            endcase
         end
         default: handled_in = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         col_ff  <= '0;
         caps_ff <= 1'b0;
      end else if (cmd.exec) begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         col_ff  <= col_in;
         caps_ff <= caps_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         read_bit_ff <= read_bit_in;
         handled_ff  <= handled_in;
      end
   end

   assign rsp_read_bit = read_bit_ff;
   assign rsp_handled  = handled_ff;

endmodule

// File: hdl/keyboard_matrix_key_queue.sv
// Channel   Direction  Handshake          Payload
// req       in         req_valid/stall    opcode, bit_address, write_bit, host_key
// rsp       out        rsp_valid/stall    read_bit, handled
//
// Each item passes through an accept step, an execute step and a result step; with
// the result taken at once and the next item waiting, the next item is accepted as
// the result leaves, not before.
// Reset is synchronous and clears pointers, column select, caps flag and control.
// A stalled result holds the block; the next item is accepted as the result leaves.
// Top level of the keyboard key queue; uses kbq_pkg, kbq_ctrl, kbq_dp and
// the assertion macros in assert_macros.svh.
`include "assert_macros.svh"
module keyboard_matrix_key_queue
   import kbq_pkg::*;
#(
   parameter int QUEUE_DEPTH = KBQ_QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_opcode,
   input  logic [4:0]  req_bit_address,
   input  logic        req_write_bit,
   input  logic [23:0] req_host_key,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_read_bit,
   output logic        rsp_handled
);

   kbq_cmd_type cmd;

   kbq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   kbq_dp #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_opcode      (req_opcode),
      .req_bit_address (req_bit_address),
      .req_write_bit   (req_write_bit),
      .req_host_key    (req_host_key),
      .rsp_read_bit    (rsp_read_bit),
      .rsp_handled     (rsp_handled)
   );

   `ASSERT_NEXT(a_one_item_at_a_time, clock, reset, req_valid && !req_stall, req_stall)
   `ASSERT_NEXT(a_exec_gives_result, clock, reset, cmd.exec, rsp_valid)
   `ASSERT_IMPLIES(a_unhandled_reads_high, clock, reset, rsp_valid && !rsp_handled, rsp_read_bit)

endmodule

// File: tb/kbq_checker.sv
// Checker for the keyboard key queue: watches both channels, predicts every result
// from its own copy of the queue, column select and caps flag, and counts mismatches.
// Depends on kbq_pkg for the opcode type, address codes and flag constants.
`timescale 1ns / 1ps

module kbq_checker
   import kbq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [1:0]  req_opcode,
   input  logic [4:0]  req_bit_address,
   input  logic        req_write_bit,
   input  logic [23:0] req_host_key,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic        rsp_read_bit,
   input  logic        rsp_handled,
   output int          fail_count,
   output int          pending,
   output int          items_seen,
   output int          key_pushes,
   output int          key_pops,
   output int          pressed_reads
);

   localparam int PTR_W = $clog2(KBQ_QUEUE_DEPTH);

   // Positions of the modifier flags in a key entry.
   localparam int ENT_FN    = 8;
   localparam int ENT_SHIFT = 9;
   localparam int ENT_CTRL  = 10;

   // Key matrix, row by row; a row is picked by the read address minus 3.
   localparam logic [0:7][0:5][7:0] KEY_GRID = {
      "=.,MN/", " LKJH;", 8'h0A, "OIUYP", 8'h00, "98760",
      8'h00, "23451", 8'h00, "SDFGA", 8'h00, "WERTQ", 8'h00, "XCVBZ"
   };

   typedef struct packed {
      logic read_bit;
      logic handled;
   } scan_result_type;

   scan_result_type  expected_bits[$];
   logic [10:0]      key_ring [KBQ_QUEUE_DEPTH];
   logic [PTR_W-1:0] ring_head;
   logic [PTR_W-1:0] ring_tail;
   logic [2:0]       col_sel;
   logic             caps_on;

   initial begin
      fail_count    = 0;
      pending       = 0;
      items_seen    = 0;
      key_pushes    = 0;
      key_pops      = 0;
      pressed_reads = 0;
   end

   function automatic logic [PTR_W-1:0] ring_step(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(KBQ_QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   // Host key code to key entry {ctrl, shift, fn, character}.
   function automatic logic [10:0] encode_key(input logic [23:0] hk);
      logic [7:0] lo;
      lo = hk[7:0];
      if (hk == HK_LEFT) return {FLAG_FN, "S"};
      if (hk == HK_RIGHT) return {FLAG_FN, "D"};
      if (hk == HK_UP) return {FLAG_FN, "E"};
      if (hk == HK_DOWN) return {FLAG_FN, "X"};
      if (hk[23:8] == 16'h0000) begin
         case (lo) inside
            8'h7E: return {FLAG_FN, "W"};       // tilde
            8'h5B: return {FLAG_FN, "R"};       // open bracket
            8'h5D: return {FLAG_FN, "T"};       // close bracket
            8'h5F: return {FLAG_FN, "U"};       // underscore
            8'h3F: return {FLAG_FN, "I"};       // question mark
            8'h27: return {FLAG_FN, "O"};       // single quote
            8'h22: return {FLAG_FN, "P"};       // double quote
            8'h7C: return {FLAG_FN, "A"};       // bar
            8'h7B: return {FLAG_FN, "F"};       // open brace
            8'h7D: return {FLAG_FN, "G"};       // close brace
            8'h5C: return {FLAG_FN, "Z"};       // backslash
            8'h60: return {FLAG_FN, "C"};       // back quote
            8'h21: return {FLAG_SHIFT, "1"};
            8'h40: return {FLAG_SHIFT, "2"};
            8'h23: return {FLAG_SHIFT, "3"};
            8'h24: return {FLAG_SHIFT, "4"};
            8'h25: return {FLAG_SHIFT, "5"};
            8'h5E: return {FLAG_SHIFT, "6"};
            8'h26: return {FLAG_SHIFT, "7"};
            8'h2A: return {FLAG_SHIFT, "8"};
            8'h28: return {FLAG_SHIFT, "9"};
            8'h29: return {FLAG_SHIFT, "0"};
            8'h2B: return {FLAG_SHIFT, "="};
            8'h2D: return {FLAG_SHIFT, "/"};
            8'h3A: return {FLAG_SHIFT, ";"};
            8'h3C: return {FLAG_SHIFT, ","};
            8'h3E: return {FLAG_SHIFT, "."};
            8'h0A, 8'h0D: return {FLAG_NONE, 8'h0A};
            HK_BKSP[7:0], HK_DEL[7:0]: return {FLAG_FN, "S"};
            default: ;
         endcase
      end
      // Remaining control codes become ctrl plus the letter 0x40 above them.
      if (hk < HK_ESC) return {FLAG_CTRL, 8'(8'h40 + lo)};
      if (hk[23:16] == 8'h00 && lo == HK_ESC[7:0]) return {FLAG_FN, hk[15:8]};
      if (lo >= "A" && lo <= "Z") return {FLAG_SHIFT, lo};
      if (lo >= "a" && lo <= "z") return {FLAG_NONE, 8'(lo - 8'h20)};
      return {FLAG_NONE, lo};
   endfunction

   task automatic predict_item(input kbq_op_type op, input logic [4:0] addr,
                               input logic wbit, input logic [23:0] hk);
      scan_result_type res;
      logic [10:0]     ent;
      logic [2:0]      row;
      res.read_bit = 1'b1;
      res.handled  = 1'b0;
      ent = key_ring[ring_tail];
      row = 3'(addr - ADDR_ROW_FIRST);
      case (op)
         OP_PUSH: begin
            // No overflow check: a full wrap makes the queue look empty.
            key_ring[ring_head] = encode_key(hk);
            ring_head = ring_step(ring_head);
            key_pushes++;
         end
         OP_READ: begin
            if (addr >= ADDR_ROW_FIRST && addr <= ADDR_ROW_LAST) begin
               res.handled = 1'b1;
               if ((caps_on || addr != ADDR_FN) && ring_head != ring_tail) begin
                  if (col_sel == 3'd0 && addr > ADDR_LAST_COL) begin
                     case (addr)
                        ADDR_FN:    res.read_bit = ~ent[ENT_FN];
                        ADDR_SHIFT: res.read_bit = ~ent[ENT_SHIFT];
                        ADDR_CTRL:  res.read_bit = ~ent[ENT_CTRL];
                        default:    ;
                     endcase
                  end else begin
                     // The pop happens first, but the entry read before it is compared.
                     if (col_sel == 3'd0 && addr == ADDR_ROW_FIRST) begin
                        ring_tail = ring_step(ring_tail);
                        key_pops++;
                     end
                     if (col_sel < COL_FIRST_DEAD && KEY_GRID[row][col_sel] == ent[7:0])
                        res.read_bit = 1'b0;
                  end
               end
            end
         end
         OP_WRITE: begin
            if (addr >= ADDR_COL0 && addr <= ADDR_COL2) begin
               col_sel[2'(addr - ADDR_COL0)] = wbit;
               res.handled = 1'b1;
            end else if (addr == ADDR_CAPS) begin
               caps_on = wbit;
               res.handled = 1'b1;
            end
         end
         default: ;
      endcase
      expected_bits.push_back(res);
   endtask

   always @(posedge clock) begin
      scan_result_type want;
      if (reset) begin
         for (int i = 0; i < KBQ_QUEUE_DEPTH; i++)
            key_ring[i] = '0;
         ring_head = '0;
         ring_tail = '0;
         col_sel   = 3'd0;
         caps_on   = 1'b0;
         expected_bits.delete();
      end else begin
         if (req_valid && !req_stall) begin
            predict_item(kbq_op_type'(req_opcode), req_bit_address, req_write_bit,
                         req_host_key);
            items_seen++;
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_bits.size() == 0) begin
               $display("%0t ns: result with no item waiting, read_bit %0b handled %0b",
                        $time, rsp_read_bit, rsp_handled);
               fail_count++;
            end else begin
               want = expected_bits.pop_front();
               if (rsp_read_bit !== want.read_bit) begin
                  $display("%0t ns: read_bit expected %0b, got %0b",
                           $time, want.read_bit, rsp_read_bit);
                  fail_count++;
               end
               if (rsp_handled !== want.handled) begin
                  $display("%0t ns: handled expected %0b, got %0b",
                           $time, want.handled, rsp_handled);
                  fail_count++;
               end
               if (rsp_read_bit === 1'b0)
                  pressed_reads++;
            end
         end
      end
      pending = expected_bits.size();
   end

endmodule

// File: tb/tb_keyboard_matrix_key_queue.sv
// Testbench top for the keyboard key queue: clock, reset, item stimulus with random
// gaps and result stalls, a watchdog and the verdict. Uses kbq_pkg and kbq_checker.
`timescale 1ns / 1ps

module tb_keyboard_matrix_key_queue;
   import kbq_pkg::*;

   localparam int RANDOM_ITEMS  = 600;
   localparam int HOLD_CYCLES   = 400;
   localparam int IDLE_LIMIT    = 5000;
   localparam int DRAIN_CYCLES  = 20;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_opcode = OP_NONE;
   logic [4:0]  req_bit_address = '0;
   logic        req_write_bit = 1'b0;
   logic [23:0] req_host_key = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_read_bit;
   logic        rsp_handled;

   int fail_count;
   int pending;
   int items_seen;
   int key_pushes;
   int key_pops;
   int pressed_reads;

   int items_sent = 0;
   int calm_left = 0;
   bit hold_done = 1'b0;

   keyboard_matrix_key_queue i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_opcode      (req_opcode),
      .req_bit_address (req_bit_address),
      .req_write_bit   (req_write_bit),
      .req_host_key    (req_host_key),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_read_bit    (rsp_read_bit),
      .rsp_handled     (rsp_handled)
   );

   kbq_checker i_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_opcode      (req_opcode),
      .req_bit_address (req_bit_address),
      .req_write_bit   (req_write_bit),
      .req_host_key    (req_host_key),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_read_bit    (rsp_read_bit),
      .rsp_handled     (rsp_handled),
      .fail_count      (fail_count),
      .pending         (pending),
      .items_seen      (items_seen),
      .key_pushes      (key_pushes),
      .key_pops        (key_pops),
      .pressed_reads   (pressed_reads)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Offers one item, waits for it to be taken, then maybe leaves a gap.
   task automatic send_item(input kbq_op_type op, input logic [4:0] addr,
                            input logic wbit, input logic [23:0] key);
      int gap;
      int r;
      req_valid       <= 1'b1;
      req_opcode      <= op;
      req_bit_address <= addr;
      req_write_bit   <= wbit;
      req_host_key    <= key;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (op != OP_NONE)
         items_sent++;
      if (calm_left == 0 && $urandom_range(0, 49) == 0)
         calm_left = $urandom_range(30, 60);
      r = $urandom_range(0, 99);
      if (calm_left > 0) begin
         calm_left--;
         gap = 0;
      end else if (r < 55) begin
         gap = 0;
      end else if (r < 88) begin
         gap = $urandom_range(1, 3);
      end else if (r < 98) begin
         gap = $urandom_range(4, 10);
      end else begin
         gap = $urandom_range(20, 40);
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic select_column(input logic [2:0] c);
      send_item(OP_WRITE, ADDR_COL0, c[0], 24'($urandom));
      send_item(OP_WRITE, ADDR_COL1, c[1], 24'($urandom));
      send_item(OP_WRITE, ADDR_COL2, c[2], 24'($urandom));
   endtask

   // Result side: random stalls, calm stretches, and one long hold-off that stalls
   // the block while items keep being offered.
   initial begin
      int r;
      int run;
      wait (!reset);
      forever begin
         if (!hold_done && items_sent >= 200) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_done = 1'b1;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 50) begin
               rsp_stall <= 1'b0;
               run = $urandom_range(1, 40);
            end else if (r < 85) begin
               rsp_stall <= 1'b1;
               run = $urandom_range(1, 3);
            end else if (r < 97) begin
               rsp_stall <= 1'b1;
               run = $urandom_range(4, 12);
            end else begin
               rsp_stall <= 1'b1;
               run = $urandom_range(20, 60);
            end
            repeat (run) @(posedge clock);
         end
      end
   end

   // Ends the run when no item moves on either channel for too long.
   initial begin
      int idle;
      idle = 0;
      wait (!reset);
      forever begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle = 0;
         else
            idle++;
         if (idle >= IDLE_LIMIT) begin
            $display("Timeout: no item moved for %0d cycles, %0d results outstanding",
                     IDLE_LIMIT, pending);
            $display("FAILURE");
            $finish;
         end
      end
   end

   initial begin
      int          target;
      int          r;
      int          n;
      logic [23:0] key;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: empty queue, range edges, extreme and special host keys,
      // column 0 modifiers and pop, dead columns, ignored writes, caps off.
      send_item(OP_READ, ADDR_ROW_FIRST, 1'b0, '0);
      send_item(OP_READ, 5'd0, 1'b1, 24'hFFFFFF);
      send_item(OP_WRITE, ADDR_CAPS, 1'b1, '0);
      send_item(OP_PUSH, 5'd31, 1'b0, 24'h000000);
      send_item(OP_READ, ADDR_CTRL, 1'b0, '0);
      send_item(OP_READ, ADDR_ROW_FIRST, 1'b0, '0);
      send_item(OP_PUSH, 5'd0, 1'b0, 24'hFFFFFF);
      send_item(OP_PUSH, 5'd0, 1'b0, HK_ESC);
      send_item(OP_PUSH, 5'd0, 1'b0, HK_UP);
      send_item(OP_PUSH, 5'd0, 1'b0, HK_LEFT);
      send_item(OP_PUSH, 5'd0, 1'b0, 24'h00000D);
      send_item(OP_PUSH, 5'd0, 1'b0, 24'h000061);
      send_item(OP_PUSH, 5'd0, 1'b0, 24'h00007E);
      send_item(OP_PUSH, 5'd0, 1'b0, 24'h000021);
      select_column(3'd7);
      send_item(OP_READ, ADDR_ROW_LAST, 1'b0, '0);
      send_item(OP_WRITE, 5'd31, 1'b1, '0);
      send_item(OP_NONE, 5'd21, 1'b1, 24'hFFFFFF);
      select_column(3'd0);
      send_item(OP_READ, ADDR_FN, 1'b0, '0);
      send_item(OP_WRITE, ADDR_CAPS, 1'b0, '0);
      send_item(OP_READ, ADDR_FN, 1'b0, '0);

      target = items_sent + RANDOM_ITEMS;
      while (items_sent < target) begin
         case ($urandom_range(0, 9))
            0, 1, 2: begin
               n = $urandom_range(1, 3);
               repeat (n) begin
                  r = $urandom_range(0, 99);
                  if (r < 35) begin
                     key = 24'($urandom_range(8'h20, 8'h7E));
                  end else if (r < 47) begin
                     case ($urandom_range(0, 8))
                        0:       key = HK_BKSP;
                        1:       key = HK_DEL;
                        2:       key = HK_ESC;
                        3:       key = HK_UP;
                        4:       key = HK_DOWN;
                        5:       key = HK_RIGHT;
                        6:       key = HK_LEFT;
                        7:       key = 24'h00000A;
                        default: key = 24'h00000D;
                     endcase
                  end else if (r < 57) begin
                     key = 24'($urandom_range(0, 26));
                  end else if (r < 67) begin
                     key = {8'h00, 8'($urandom), HK_ESC[7:0]};
                  end else begin
                     key = 24'($urandom);
                  end
                  send_item(OP_PUSH, 5'($urandom), 1'($urandom), key);
               end
            end
            3, 4: begin
               // Scan a column: select it, then read a few rows.
               if ($urandom_range(0, 99) < 85)
                  select_column(3'($urandom_range(0, 5)));
               else
                  select_column(3'($urandom_range(6, 7)));
               n = $urandom_range(1, 4);
               repeat (n)
                  send_item(OP_READ, 5'($urandom_range(ADDR_ROW_FIRST, ADDR_ROW_LAST)),
                            1'($urandom), 24'($urandom));
            end
            5: begin
               // Modifier check and pop at column 0.
               select_column(3'd0);
               send_item(OP_READ, 5'($urandom_range(ADDR_FN, ADDR_CTRL)), 1'($urandom),
                         24'($urandom));
               send_item(OP_READ, ADDR_ROW_FIRST, 1'($urandom), 24'($urandom));
            end
            6: begin
               send_item(OP_WRITE, ADDR_CAPS, 1'($urandom_range(0, 99) < 75),
                         24'($urandom));
            end
            7, 8: begin
               if ($urandom_range(0, 99) < 80)
                  send_item(OP_READ, 5'($urandom_range(ADDR_ROW_FIRST, ADDR_ROW_LAST)),
                            1'($urandom), 24'($urandom));
               else
                  send_item(OP_READ, 5'($urandom), 1'($urandom), 24'($urandom));
            end
            default: begin
               r = $urandom_range(0, 99);
               if (r < 60)
                  send_item(OP_WRITE, 5'($urandom_range(ADDR_COL0, ADDR_CAPS)),
                            1'($urandom), 24'($urandom));
               else if (r < 85)
                  send_item(OP_WRITE, 5'($urandom), 1'($urandom), 24'($urandom));
               else
                  send_item(OP_NONE, 5'($urandom), 1'($urandom), 24'($urandom));
            end
         endcase
      end

      req_valid <= 1'b0;
      @(posedge clock);
      wait (pending == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run covered %0d items: %0d key pushes, %0d queue pops, %0d pressed reads.",
               items_seen, key_pushes, key_pops, pressed_reads);
      $display("Result side held off for %0d cycles once while items kept coming.",
               HOLD_CYCLES);
      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("%0d mismatches", fail_count);
         $display("FAILURE");
      end
      $finish;
   end

endmodule
